[rtl/core/tcer_pkg.sv]
// Shared types and constants for the touch contact edge replay block.
package tcer_pkg;

	localparam int COORD_W        = 12;
	localparam int TIME_W         = 32;
	localparam int COUNT_W        = 32;
	localparam int RUN_W          = 4;
	localparam int STALE_W        = 16;
	localparam int BACKLOG_W      = 2;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 16;
	localparam int POINT_SLOTS_DEF = 4;

	// Register map
	localparam logic [CFG_INDEX_W-1:0] REG_LIFT_SAMPLES   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STALE_LIMIT_MS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BACKLOG_LIMIT  = 2'd2;

	localparam logic [RUN_W-1:0]     LIFT_SAMPLES_RST   = 4'd4;
	localparam logic [STALE_W-1:0]   STALE_LIMIT_RST    = 16'd1000;
	localparam logic [BACKLOG_W-1:0] BACKLOG_LIMIT_RST  = 2'd3;

	typedef enum logic {
		OP_SAMPLE    = 1'b0,
		OP_EDGE_READ = 1'b1
	} opcode_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} point_t;

	typedef struct packed {
		opcode_t            opcode;
		logic               raw_down;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [TIME_W-1:0]  now_ms;
	} item_t;

	typedef struct packed {
		logic [RUN_W-1:0]     lift_samples;
		logic [STALE_W-1:0]   stale_limit_ms;
		logic [BACKLOG_W-1:0] backlog_limit;
	} cfg_t;

	typedef struct packed {
		logic   down;
		point_t pt;
	} level_t;

endpackage

[rtl/core/tcer_req_if.sv]
// Request channel: raw touch samples and edge reads.
interface tcer_req_if import tcer_pkg::*; ();
	logic                valid;
	logic                ready;
	opcode_t             opcode;
	logic                raw_down;
	logic [COORD_W-1:0]  pos_x;
	logic [COORD_W-1:0]  pos_y;
	logic [TIME_W-1:0]   now_ms;

	modport source (output valid, opcode, raw_down, pos_x, pos_y, now_ms, input ready);
	modport sink   (input valid, opcode, raw_down, pos_x, pos_y, now_ms, output ready);
endinterface

[rtl/core/tcer_rsp_if.sv]
// Result channel: debounced level and replayed edge.
interface tcer_rsp_if import tcer_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                level_down;
	logic [COORD_W-1:0]  level_x;
	logic [COORD_W-1:0]  level_y;
	logic                edge_pressed;
	logic [COORD_W-1:0]  edge_x;
	logic [COORD_W-1:0]  edge_y;

	modport source (output valid, level_down, level_x, level_y, edge_pressed, edge_x, edge_y,
		input ready);
	modport sink   (input valid, level_down, level_x, level_y, edge_pressed, edge_x, edge_y,
		output ready);
endinterface

[rtl/core/tcer_point_mem.sv]
// Contact point ring: one write port, one registered read port.
module tcer_point_mem import tcer_pkg::*; #(
	parameter int POINT_SLOTS = POINT_SLOTS_DEF,
	localparam int SLOT_W = $clog2(POINT_SLOTS)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [SLOT_W-1:0] wr_slot,
	input  point_t            wr_pt,
	input  logic              rd_en,
	input  logic [SLOT_W-1:0] rd_slot,
	output point_t            rd_pt
);

	point_t mem [POINT_SLOTS];
	point_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_slot] <= wr_pt;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_slot];
		end
	end

	assign rd_pt = rd_q;

endmodule

[rtl/core/tcer_ctrl.sv]
// Debounce, contact counters and reader replay state; drives the point ring.
module tcer_ctrl import tcer_pkg::*; #(
	parameter int POINT_SLOTS = POINT_SLOTS_DEF,
	localparam int SLOT_W = $clog2(POINT_SLOTS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  item_t             item,
	input  cfg_t              cfg,
	output level_t            level,
	output logic              pressed,
	output logic              wr_en,
	output logic [SLOT_W-1:0] wr_slot,
	output point_t            wr_pt,
	output logic              rd_en,
	output logic [SLOT_W-1:0] rd_slot
);

	// slot of 2^32-1, where a count wraps back to zero
	localparam int unsigned TOP_SLOT = 32'hFFFF_FFFF % POINT_SLOTS;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s,
		input logic [COUNT_W-1:0] n);
		logic [SLOT_W-1:0] r;
		if (n == '1 || s == SLOT_W'(POINT_SLOTS - 1)) begin
			r = '0;
		end else begin
			r = s + 1'b1;
		end
		return r;
	endfunction

	// slot of n-k given the slot of n, k up to 3
	function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] s,
		input logic [COUNT_W-1:0] n, input logic [BACKLOG_W-1:0] k);
		logic [SLOT_W-1:0] r;
		r = s;
		for (int i = 0; i < 3; i++) begin
			if (BACKLOG_W'(i) < k) begin
				if (n == COUNT_W'(i)) begin
					r = SLOT_W'(TOP_SLOT);
				end else if (r == '0) begin
					r = SLOT_W'(POINT_SLOTS - 1);
				end else begin
					r = r - 1'b1;
				end
			end
		end
		return r;
	endfunction

	logic               finger_q,  nx_finger;
	logic [RUN_W-1:0]   empty_q,   nx_empty;
	logic [COUNT_W-1:0] press_q,   nx_press;
	logic [COUNT_W-1:0] lift_q,    nx_lift;
	logic [SLOT_W-1:0]  pslot_q,   nx_pslot;
	point_t             live_q,    nx_live;
	logic [TIME_W-1:0]  end_q,     nx_end;
	logic               seen_q,    nx_seen;
	logic               held_q,    nx_held;
	logic [COUNT_W-1:0] rpress_q,  nx_rpress;
	logic [COUNT_W-1:0] rlift_q,   nx_rlift;
	logic [COUNT_W-1:0] judged_q,  nx_judged;
	logic [SLOT_W-1:0]  rslot_q,   nx_rslot;
	logic [TIME_W-1:0]  newest;
	logic [TIME_W-1:0]  age;
	logic [COUNT_W-1:0] gap;

	always_comb begin
		nx_finger = finger_q;
		nx_empty  = empty_q;
		nx_press  = press_q;
		nx_lift   = lift_q;
		nx_pslot  = pslot_q;
		nx_live   = live_q;
		nx_end    = end_q;
		nx_seen   = seen_q;
		nx_held   = held_q;
		nx_rpress = rpress_q;
		nx_rlift  = rlift_q;
		nx_judged = judged_q;
		nx_rslot  = rslot_q;
		newest    = '0;
		age       = '0;
		gap       = '0;
		wr_en     = 1'b0;
		pressed   = 1'b0;
		if (accept) begin
			case (item.opcode)
				OP_SAMPLE: begin
					if (item.raw_down) begin
						nx_empty = '0;
					end else if (empty_q < cfg.lift_samples) begin
						nx_empty = empty_q + 1'b1;
					end
					if (item.raw_down) begin
						if (!finger_q) begin
							nx_finger = 1'b1;
							nx_press  = press_q + 1'b1;
							nx_pslot  = slot_inc(pslot_q, press_q);
						end
						wr_en   = 1'b1;
						nx_live = '{x: item.pos_x, y: item.pos_y};
					end else if (nx_empty >= cfg.lift_samples && finger_q) begin
						nx_finger = 1'b0;
						nx_lift   = lift_q + 1'b1;
						nx_end    = item.now_ms;
					end
				end
				OP_EDGE_READ: begin
					// first read: jump to the present
					if (!seen_q) begin
						nx_seen   = 1'b1;
						nx_rpress = press_q;
						nx_rlift  = lift_q;
						nx_held   = finger_q;
						nx_judged = press_q;
						nx_rslot  = pslot_q;
					end
					// judge a new backlog once by its newest contact's age
					if (press_q != nx_rpress && press_q != nx_judged) begin
						newest    = finger_q ? item.now_ms : end_q;
						age       = item.now_ms - newest;
						nx_judged = press_q;
						if (age > TIME_W'(cfg.stale_limit_ms)) begin
							nx_rpress = press_q;
							nx_rlift  = lift_q;
							nx_held   = finger_q;
							nx_rslot  = pslot_q;
						end
					end
					// trim, keeping an owed lift
					gap = press_q - nx_rpress;
					if (gap > COUNT_W'(cfg.backlog_limit)) begin
						nx_rpress = press_q - COUNT_W'(cfg.backlog_limit);
						nx_rslot  = slot_back(pslot_q, press_q, cfg.backlog_limit);
						nx_rlift  = nx_held ? nx_rpress - 1'b1 : nx_rpress;
					end
					// hand over one edge
					if (nx_held) begin
						if (nx_rlift != lift_q) begin
							nx_rlift = nx_rlift + 1'b1;
							nx_held  = 1'b0;
						end else begin
							pressed = 1'b1;
						end
					end else if (nx_rpress != press_q) begin
						nx_rslot  = slot_inc(nx_rslot, nx_rpress);
						nx_rpress = nx_rpress + 1'b1;
						nx_held   = 1'b1;
						pressed   = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign wr_slot = nx_pslot;
	assign wr_pt   = nx_live;
	assign rd_en   = pressed;
	assign rd_slot = nx_rslot;

	assign level.down = nx_finger;
	assign level.pt   = nx_finger ? nx_live : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finger_q <= 1'b0;
			empty_q  <= '0;
			press_q  <= '0;
			lift_q   <= '0;
			pslot_q  <= '0;
			end_q    <= '0;
			seen_q   <= 1'b0;
			held_q   <= 1'b0;
			rpress_q <= '0;
			rlift_q  <= '0;
			judged_q <= '0;
			rslot_q  <= '0;
		end else begin
			finger_q <= nx_finger;
			empty_q  <= nx_empty;
			press_q  <= nx_press;
			lift_q   <= nx_lift;
			pslot_q  <= nx_pslot;
			end_q    <= nx_end;
			seen_q   <= nx_seen;
			held_q   <= nx_held;
			rpress_q <= nx_rpress;
			rlift_q  <= nx_rlift;
			judged_q <= nx_judged;
			rslot_q  <= nx_rslot;
		end
	end

	// newest contact's point, mirrors its ring entry
	always_ff @(posedge clk) begin
		live_q <= nx_live;
	end

endmodule

[rtl/core/touch_contact_edge_replay.sv]
// Top level: touch debounce and contact edge replay with config and output stage.
//
// Usage:
// - req carries one request per item: a raw touch sample (finger flag, x, y,
//   time) or an edge read from the gesture reader (time only).
// - rsp returns exactly one result per request: the debounced level and live
//   point, plus for edge reads at most one replayed press or lift; a press
//   carries that contact's own point.
// - A request accepted at an edge shows on rsp right after it. One request
//   per cycle is sustained while rsp.ready stays high; all control state
//   updates at once, and the point ring is read at most once per edge read.
// - The result sits in an output register. req.ready stays high while that
//   register is empty or being taken, so a stalled receiver holds the result
//   and stops further requests, with nothing lost.
// - Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) are registered;
//   write them only while no request is in flight.
// - Reset clears all counters and reader state and loads the register
//   defaults; the point ring is not cleared and needs no clearing pass.
module touch_contact_edge_replay import tcer_pkg::*; #(
	parameter int POINT_SLOTS = POINT_SLOTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	tcer_req_if.sink               req,
	tcer_rsp_if.source             rsp
);

	localparam int SLOT_W = $clog2(POINT_SLOTS);

	cfg_t              cfg_q;
	item_t             item;
	logic              accept;
	level_t            level;
	logic              pressed;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_slot;
	point_t            wr_pt;
	logic              rd_en;
	logic [SLOT_W-1:0] rd_slot;
	point_t            rd_pt;
	logic              valid_q;
	level_t            level_s1;
	logic              pressed_s1;

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lift_samples   <= LIFT_SAMPLES_RST;
			cfg_q.stale_limit_ms <= STALE_LIMIT_RST;
			cfg_q.backlog_limit  <= BACKLOG_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_LIFT_SAMPLES:   cfg_q.lift_samples   <= cfg_wdata[RUN_W-1:0];
				REG_STALE_LIMIT_MS: cfg_q.stale_limit_ms <= cfg_wdata[STALE_W-1:0];
				REG_BACKLOG_LIMIT:  cfg_q.backlog_limit  <= cfg_wdata[BACKLOG_W-1:0];
				default: ;
			endcase
		end
	end

	// Take a request whenever the output register is free or draining
	assign req.ready = !valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign item.opcode   = req.opcode;
	assign item.raw_down = req.raw_down;
	assign item.pos_x    = req.pos_x;
	assign item.pos_y    = req.pos_y;
	assign item.now_ms   = req.now_ms;

	tcer_ctrl #(
		.POINT_SLOTS(POINT_SLOTS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.cfg     (cfg_q),
		.level   (level),
		.pressed (pressed),
		.wr_en   (wr_en),
		.wr_slot (wr_slot),
		.wr_pt   (wr_pt),
		.rd_en   (rd_en),
		.rd_slot (rd_slot)
	);

	// Ring read data lines up with the output stage; it only moves on accept,
	// so it holds while the receiver stalls
	tcer_point_mem #(
		.POINT_SLOTS(POINT_SLOTS)
	) u_point_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_slot (wr_slot),
		.wr_pt   (wr_pt),
		.rd_en   (rd_en),
		.rd_slot (rd_slot),
		.rd_pt   (rd_pt)
	);

	// Output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			pressed_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_q    <= 1'b1;
				pressed_s1 <= pressed;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			level_s1 <= level;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.level_down   = level_s1.down;
	assign rsp.level_x      = level_s1.pt.x;
	assign rsp.level_y      = level_s1.pt.y;
	assign rsp.edge_pressed = pressed_s1;
	assign rsp.edge_x       = pressed_s1 ? rd_pt.x : '0;
	assign rsp.edge_y       = pressed_s1 ? rd_pt.y : '0;

endmodule
